@@ hdl/pfaa_pkg.sv @@
package pfaa_pkg;

  localparam int COORD_BITS = 16;
  localparam int ACC_BITS   = 48;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;
  // |cross| never exceeds 2^(PROD_BITS-1), so it fits PROD_BITS unsigned bits
  localparam int TERM_BITS  = PROD_BITS;

  localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

  typedef logic [1:0] vcount_t;
  localparam vcount_t CNT_NONE = 2'd0;
  localparam vcount_t CNT_TWO  = 2'd2;
  localparam vcount_t CNT_MANY = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    logic   final_vertex;
  } vertex_t;

  typedef struct packed {
    logic [ACC_BITS-1:0] area_halves;
    logic                too_few_points;
    logic                saturated;
  } result_t;

  // one fan triangle on its way to the accumulator
  typedef struct packed {
    logic [TERM_BITS-1:0] term;
    logic                 add_en;
    logic                 last;
    logic                 few;
  } term_t;

endpackage

@@ hdl/polygon_fan_area_accumulator_core.sv @@
// Polygon fan area accumulator. Feed vertices one per transfer; flag the
// last one with final_vertex. From the third vertex on, twice the area of
// the fan triangle (first, previous, current) is added to a 48-bit sum that
// clamps at its maximum. The last vertex produces one result: the doubled
// total, or too_few_points with zero area for fewer than three vertices;
// other vertices produce none. The area is exact for convex polygons. A
// vertex is taken every cycle unless a last vertex is held back by a stalled
// output. A transfer loads the vertex register; from there a vertex moves to
// the cross-product register fed by two 17x17 multipliers, and a last vertex
// then loads the result register from the accumulate-and-clamp stage. Only
// the last vertex waits on a stalled output.
module polygon_fan_area_accumulator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfaa_pkg::vertex_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pfaa_pkg::result_t out_data
);
  import pfaa_pkg::*;

  logic  term_valid, term_take;
  term_t term_data;

  pfaa_term u_term (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .term_valid (term_valid),
    .term_data  (term_data),
    .term_take  (term_take)
  );

  pfaa_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .term_valid (term_valid),
    .term_data  (term_data),
    .term_take  (term_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

@@ hdl/pfaa_term.sv @@
module pfaa_term (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfaa_pkg::vertex_t in_data,
  output logic              term_valid,
  output pfaa_pkg::term_t   term_data,
  input  logic              term_take
);
  import pfaa_pkg::*;

  logic    s1_valid_r, s1_valid_nxt;
  vertex_t s1_data_r;
  coord_t  first_x_r, first_y_r, prev_x_r, prev_y_r;
  vcount_t cnt_r;
  logic    term_valid_r, term_valid_nxt;
  term_t   term_r, term_nxt;

  logic s2_free, s1_adv, in_xfer;

  logic signed [DIFF_BITS-1:0]  dpx, dpy, dcx, dcy;
  logic signed [PROD_BITS-1:0]  prod_a, prod_b;
  logic signed [CROSS_BITS-1:0] cross_prod, cross_mag;

  assign s2_free  = !term_valid_r || term_take;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_xfer  = in_valid && !in_stall;

  assign s1_valid_nxt   = in_xfer || (s1_valid_r && !s1_adv);
  assign term_valid_nxt = s1_adv || (term_valid_r && !term_take);

  // doubled fan triangle area: |(prev - first) x (cur - first)|
  always_comb begin
    dpx        = DIFF_BITS'(prev_x_r) - DIFF_BITS'(first_x_r);
    dpy        = DIFF_BITS'(prev_y_r) - DIFF_BITS'(first_y_r);
    dcx        = DIFF_BITS'(s1_data_r.vertex_x) - DIFF_BITS'(first_x_r);
    dcy        = DIFF_BITS'(s1_data_r.vertex_y) - DIFF_BITS'(first_y_r);
    prod_a     = dpx * dcy;
    prod_b     = dpy * dcx;
    cross_prod = CROSS_BITS'(prod_a) - CROSS_BITS'(prod_b);
    cross_mag  = cross_prod[CROSS_BITS-1] ? -cross_prod : cross_prod;
    term_nxt.term   = cross_mag[TERM_BITS-1:0];
    term_nxt.add_en = (cnt_r >= CNT_TWO);
    term_nxt.few    = (cnt_r < CNT_TWO);
    term_nxt.last   = s1_data_r.final_vertex;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      term_valid_r <= 1'b0;
      cnt_r        <= CNT_NONE;
      first_x_r    <= '0;
      first_y_r    <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      term_valid_r <= term_valid_nxt;
      if (s1_adv) begin
        if (s1_data_r.final_vertex) begin
          // start a fresh polygon
          cnt_r     <= CNT_NONE;
          first_x_r <= '0;
          first_y_r <= '0;
          prev_x_r  <= '0;
          prev_y_r  <= '0;
        end else begin
          if (cnt_r == CNT_NONE) begin
            first_x_r <= s1_data_r.vertex_x;
            first_y_r <= s1_data_r.vertex_y;
          end
          prev_x_r <= s1_data_r.vertex_x;
          prev_y_r <= s1_data_r.vertex_y;
          if (cnt_r != CNT_MANY) begin
            cnt_r <= cnt_r + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      term_r <= term_nxt;
    end
  end

  assign term_valid = term_valid_r;
  assign term_data  = term_r;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty vertex stage");

  a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_data_r.final_vertex) |=> (cnt_r == CNT_NONE))
    else $error("vertex count not cleared after last vertex");

  a_term_held: assert property (@(posedge clk) disable iff (!rst_n)
    (term_valid_r && !term_take) |=> (term_valid_r && $stable(term_r)))
    else $error("pending fan term lost or changed");
`endif

endmodule

@@ hdl/pfaa_accum.sv @@
module pfaa_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              term_valid,
  input  pfaa_pkg::term_t   term_data,
  output logic              term_take,
  output logic              out_valid,
  input  logic              out_stall,
  output pfaa_pkg::result_t out_data
);
  import pfaa_pkg::*;

  logic [ACC_BITS-1:0] sum_r, sum_upd;
  logic                clamp_r, clamp_upd;
  logic [ACC_BITS:0]   sum_ext;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_data_r, out_data_nxt;
  logic                out_free, emit;

  assign out_free  = !out_valid_r || !out_stall;
  // only the last vertex needs room in the result register
  assign term_take = term_valid && (!term_data.last || out_free);
  assign emit      = term_take && term_data.last;

  always_comb begin
    sum_ext   = {1'b0, sum_r} + (ACC_BITS + 1)'(term_data.term);
    sum_upd   = sum_r;
    clamp_upd = clamp_r;
    if (term_data.add_en) begin
      if (sum_ext[ACC_BITS]) begin
        sum_upd   = ACC_MAX;
        clamp_upd = 1'b1;
      end else begin
        sum_upd = sum_ext[ACC_BITS-1:0];
      end
    end
    if (term_data.few) begin
      out_data_nxt.area_halves    = '0;
      out_data_nxt.too_few_points = 1'b1;
      out_data_nxt.saturated      = 1'b0;
    end else begin
      out_data_nxt.area_halves    = sum_upd;
      out_data_nxt.too_few_points = 1'b0;
      out_data_nxt.saturated      = clamp_upd;
    end
  end

  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      clamp_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (term_take) begin
        if (term_data.last) begin
          sum_r   <= '0;
          clamp_r <= 1'b0;
        end else begin
          sum_r   <= sum_upd;
          clamp_r <= clamp_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_sat_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.saturated) |-> (out_data_r.area_halves == ACC_MAX))
    else $error("saturated result below maximum");

  a_few_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.too_few_points) |->
      (out_data_r.area_halves == '0 && !out_data_r.saturated))
    else $error("short polygon reported nonzero area");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (sum_r == '0 && !clamp_r))
    else $error("running sum not cleared after result");

  a_clamp_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
    clamp_r |-> (sum_r == ACC_MAX))
    else $error("clamped sum left maximum");
`endif

endmodule
